// ----- src/line_plane_intersection_top_defines.svh -----
// ----------------------------------------------------------------------------
// Line/plane intersection - assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef LINE_PLANE_INTERSECTION_TOP_DEFINES_SVH
`define LINE_PLANE_INTERSECTION_TOP_DEFINES_SVH

// Antecedent implies consequent on the same edge, quiet during reset.
`define LPI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition never seen outside reset.
`define LPI_ASSERT_NEVER(label, bad, msg) \
  `LPI_ASSERT_IMP(label, 1'b1, !(bad), msg)

`endif

// ----- src/lpi_pkg.sv -----
// ----------------------------------------------------------------------------
// Line/plane intersection - package
// Word types, register indexes, status codes and datapath widths.
// ----------------------------------------------------------------------------
package lpi_pkg;

  localparam int COORD_W    = 32;
  localparam int NORM_W     = 18;
  localparam int OFFS_W     = 32;
  localparam int LEN_W      = 16;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // normal and cosine are both scaled by 2^16; the offset is shifted up to match
  localparam int FIX_SHIFT = 16;

  // squared direction length and its root
  localparam int SQ_W       = 2 * COORD_W;
  localparam int SQRT_STEPS = 4;
  localparam int SQRT_LAT   = (SQ_W / 2) / SQRT_STEPS;

  // squared normal length
  localparam int NN_W = 2 * NORM_W;

  // n.P, n.d and the distance, with room for the three-term sums
  localparam int NP_W   = NORM_W + COORD_W;
  localparam int PROD_W = NP_W + 2;
  localparam int MAG_W  = PROD_W - 1;

  // |dist| * |d| is formed from two partial products
  localparam int SPLIT_W = 26;
  localparam int NUM_W   = MAG_W + COORD_W;

  // quotient bits kept; anything at or above 2^QUOT_W saturates the output
  localparam int QUOT_W    = 36;
  localparam int DIV_STEPS = 4;
  localparam int DIV_LAT   = 1 + QUOT_W / DIV_STEPS;

  // accept edge to result strobe
  localparam int LATENCY = 5 + DIV_LAT;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_X       = 3'd0,
    REG_NORMAL_Y       = 3'd1,
    REG_NORMAL_Z       = 3'd2,
    REG_PLANE_OFFSET   = 3'd3,
    REG_MIN_DIR_LENGTH = 3'd4,
    REG_PARALLEL_LIMIT = 3'd5
  } lpi_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_HIT      = 2'd0,
    STATUS_DEGEN    = 2'd1,
    STATUS_PARALLEL = 2'd2
  } lpi_status_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] line_px;
    logic signed [COORD_W-1:0] line_py;
    logic signed [COORD_W-1:0] line_pz;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } lpi_line_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic signed [COORD_W-1:0] hit_z;
  } lpi_result_t;

  function automatic logic [COORD_W-1:0] coord_mag(logic signed [COORD_W-1:0] v);
    return v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
  endfunction

endpackage

// ----- src/lpi_delay.sv -----
// ----------------------------------------------------------------------------
// Line/plane intersection - delay line
// Fixed-depth shift line that keeps side data level with the datapath.
// ----------------------------------------------------------------------------
module lpi_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        tap_q[i] <= '0;
      end
    end else begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

// ----- src/lpi_isqrt.sv -----
// ----------------------------------------------------------------------------
// Line/plane intersection - pipelined square root
// Floor square root, digit by digit, STEPS result bits per stage.
// ----------------------------------------------------------------------------
module lpi_isqrt #(
  parameter int IN_W  = 64,
  parameter int STEPS = 4
) (
  input  logic              clk_i,
  input  logic [IN_W-1:0]   rad_i,
  output logic [IN_W/2-1:0] root_o
);

  localparam int ROOT_W = IN_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int STAGES = ROOT_W / STEPS;

  logic [IN_W-1:0]   rad_q  [STAGES];
  logic [ROOT_W-1:0] root_q [STAGES];
  logic [REM_W-1:0]  rem_q  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [IN_W-1:0]   rad_in, rad_d;
    logic [ROOT_W-1:0] root_in, root_d;
    logic [REM_W-1:0]  rem_in, rem_d;

    if (s == 0) begin : g_head
      assign rad_in  = rad_i;
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_body
      assign rad_in  = rad_q[s-1];
      assign root_in = root_q[s-1];
      assign rem_in  = rem_q[s-1];
    end

    always_comb begin
      logic [REM_W-1:0] rem_n;
      logic [REM_W-1:0] trial;
      rad_d  = rad_in;
      root_d = root_in;
      rem_d  = rem_in;
      for (int k = 0; k < STEPS; k++) begin
        // bring down the next two radicand bits
        rem_n = {rem_d[REM_W-3:0], rad_d[IN_W-1:IN_W-2]};
        trial = {root_d, 2'b01};
        rad_d = {rad_d[IN_W-3:0], 2'b00};
        if (rem_n >= trial) begin
          rem_d  = rem_n - trial;
          root_d = {root_d[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_n;
          root_d = {root_d[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[s]  <= rad_d;
      root_q[s] <= root_d;
      rem_q[s]  <= rem_d;
    end
  end

  assign root_o = root_q[STAGES-1];

endmodule

// ----- src/lpi_div.sv -----
// ----------------------------------------------------------------------------
// Line/plane intersection - pipelined divider
// Restoring division keeping QUOT_W quotient bits, with an overflow flag
// for quotients at or above 2^QUOT_W.
// ----------------------------------------------------------------------------
module lpi_div #(
  parameter int NUM_W  = 83,
  parameter int DEN_W  = 51,
  parameter int QUOT_W = 36,
  parameter int STEPS  = 4
) (
  input  logic              clk_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic [QUOT_W-1:0] quot_o,
  output logic              ovf_o
);

  localparam int HEAD_W = NUM_W - QUOT_W;
  localparam int REM_W  = DEN_W + 1;
  localparam int STAGES = QUOT_W / STEPS;

  logic [REM_W-1:0]  rem_q  [STAGES+1];
  logic [QUOT_W-1:0] low_q  [STAGES+1];
  logic [QUOT_W-1:0] quot_q [STAGES+1];
  logic [DEN_W-1:0]  den_q  [STAGES+1];
  logic              ovf_q  [STAGES+1];

  logic [HEAD_W-1:0] head;
  logic              head_ovf;

  // quotient overflows exactly when the top part already reaches the divisor
  assign head     = num_i[NUM_W-1:QUOT_W];
  assign head_ovf = REM_W'(head) >= REM_W'(den_i);

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= head_ovf ? '0 : REM_W'(head);
    low_q[0]  <= num_i[QUOT_W-1:0];
    quot_q[0] <= '0;
    den_q[0]  <= den_i;
    ovf_q[0]  <= head_ovf;
  end

  for (genvar s = 1; s <= STAGES; s++) begin : g_stage
    logic [REM_W-1:0]  rem_d;
    logic [QUOT_W-1:0] low_d, quot_d;

    always_comb begin
      logic [REM_W-1:0] rem_n;
      rem_d  = rem_q[s-1];
      low_d  = low_q[s-1];
      quot_d = quot_q[s-1];
      for (int k = 0; k < STEPS; k++) begin
        rem_n = {rem_d[REM_W-2:0], low_d[QUOT_W-1]};
        low_d = {low_d[QUOT_W-2:0], 1'b0};
        if (rem_n >= {1'b0, den_q[s-1]}) begin
          rem_d  = rem_n - {1'b0, den_q[s-1]};
          quot_d = {quot_d[QUOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_n;
          quot_d = {quot_d[QUOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      low_q[s]  <= low_d;
      quot_q[s] <= quot_d;
      den_q[s]  <= den_q[s-1];
      ovf_q[s]  <= ovf_q[s-1];
    end
  end

  assign quot_o = quot_q[STAGES];
  assign ovf_o  = ovf_q[STAGES];

endmodule

// ----- src/line_plane_intersection_top.sv -----
// ----------------------------------------------------------------------------
// Line/plane intersection - top level
// Intersects each line word with the configured plane n.X + d = 0.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------
//   line in  | start, busy           | line_i  (point, direction)
//   result   | done_o (one cycle)    | res_o   (status, hit point)
//   config   | cfg_we_i, cfg_idx_i   | cfg_data_i
//
// One line word per cycle. done_o rises together with res_o once the word has
// passed the product, sum, magnitude and numerator stages, the 10-stage divider
// (head plus nine quotient stages) and the output register. busy stays low: the
// pipeline never holds.
// Reset clears the configuration to its defaults and drops words in flight.
// The result side cannot stall; done_o pulses for one cycle per word.
// ----------------------------------------------------------------------------
module line_plane_intersection_top
  import lpi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  lpi_line_t             line_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output lpi_result_t           res_o
);

  localparam int SIDE_DEPTH = 1 + DIV_LAT;
  localparam int LHS_DEPTH  = SQRT_LAT + 1;
  localparam int PAR_DEPTH  = (4 + DIV_LAT) - (5 + SQRT_LAT);
  localparam int LO_W       = SPLIT_W + COORD_W;
  localparam int HI_W       = MAG_W - SPLIT_W + COORD_W;
  localparam int RHS1_W     = LEN_W + NN_W / 2;
  localparam int RHS_W      = RHS1_W + SQ_W / 2;
  localparam int LHS_W      = MAG_W + FIX_SHIFT;
  localparam int STEP_W     = QUOT_W + 1;
  localparam int H_W        = QUOT_W + 3;

  localparam logic signed [NORM_W-1:0]  NORM_ONE  = NORM_W'(65536);
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [STEP_W-1:0]         STEP_CAP  = {1'b1, {QUOT_W{1'b0}}};

  typedef struct packed {
    logic [2:0][COORD_W-1:0] p;
    logic [2:0]              neg;
    logic                    degen;
    logic                    nd_zero;
  } side_t;

  // ---------------------------------------------------------------- config
  logic signed [NORM_W-1:0] normal_q [3];
  logic signed [OFFS_W-1:0] plane_offset_q;
  logic [LEN_W-1:0]         min_dir_q;
  logic [LEN_W-1:0]         par_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_q[0]    <= '0;
      normal_q[1]    <= '0;
      normal_q[2]    <= NORM_ONE;
      plane_offset_q <= '0;
      min_dir_q      <= '0;
      par_limit_q    <= LEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NORMAL_X:       normal_q[0]    <= cfg_data_i[NORM_W-1:0];
        REG_NORMAL_Y:       normal_q[1]    <= cfg_data_i[NORM_W-1:0];
        REG_NORMAL_Z:       normal_q[2]    <= cfg_data_i[NORM_W-1:0];
        REG_PLANE_OFFSET:   plane_offset_q <= cfg_data_i[OFFS_W-1:0];
        REG_MIN_DIR_LENGTH: min_dir_q      <= cfg_data_i[LEN_W-1:0];
        REG_PARALLEL_LIMIT: par_limit_q    <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic signed [COORD_W-1:0] in_p [3];
  logic signed [COORD_W-1:0] in_d [3];

  assign in_p[0] = line_i.line_px;
  assign in_p[1] = line_i.line_py;
  assign in_p[2] = line_i.line_pz;
  assign in_d[0] = line_i.dir_x;
  assign in_d[1] = line_i.dir_y;
  assign in_d[2] = line_i.dir_z;

  // ---------------------------------------------------------------- stage 1: products
  logic signed [COORD_W-1:0] p1_q [3];
  logic signed [COORD_W-1:0] d1_q [3];
  logic [SQ_W-1:0]           dsq1_q [3];
  logic signed [NP_W-1:0]    nd1_q [3];
  logic signed [NP_W-1:0]    np1_q [3];
  logic [NN_W-1:0]           nsq1_q [3];
  logic signed [PROD_W-1:0]  off1_q;
  logic [2*LEN_W-1:0]        mm1_q;
  logic                      nzero1_q;

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      p1_q[a]   <= in_p[a];
      d1_q[a]   <= in_d[a];
      dsq1_q[a] <= coord_mag(in_d[a]) * coord_mag(in_d[a]);
      nd1_q[a]  <= normal_q[a] * in_d[a];
      np1_q[a]  <= normal_q[a] * in_p[a];
      nsq1_q[a] <= normal_q[a] * normal_q[a];
    end
    off1_q   <= PROD_W'(plane_offset_q) <<< FIX_SHIFT;
    mm1_q    <= min_dir_q * min_dir_q;
    nzero1_q <= (normal_q[0] == '0) && (normal_q[1] == '0) && (normal_q[2] == '0);
  end

  // ---------------------------------------------------------------- stage 2: sums
  logic signed [COORD_W-1:0] p2_q [3];
  logic signed [COORD_W-1:0] d2_q [3];
  logic [SQ_W-1:0]           dd2_q;
  logic signed [PROD_W-1:0]  nd2_q;
  logic signed [PROD_W-1:0]  dist2_q;
  logic [NN_W-1:0]           nn2_q;
  logic [2*LEN_W-1:0]        mm2_q;
  logic                      nzero2_q;

  always_ff @(posedge clk_i) begin
    p2_q     <= p1_q;
    d2_q     <= d1_q;
    dd2_q    <= dsq1_q[0] + dsq1_q[1] + dsq1_q[2];
    nd2_q    <= PROD_W'(nd1_q[0]) + PROD_W'(nd1_q[1]) + PROD_W'(nd1_q[2]);
    dist2_q  <= PROD_W'(np1_q[0]) + PROD_W'(np1_q[1]) + PROD_W'(np1_q[2]) + off1_q;
    nn2_q    <= nsq1_q[0] + nsq1_q[1] + nsq1_q[2];
    mm2_q    <= mm1_q;
    nzero2_q <= nzero1_q;
  end

  // roots of the squared lengths, ready SQRT_LAT stages on
  logic [SQ_W/2-1:0] root_dd;
  logic [SQ_W/2-1:0] root_nn;

  lpi_isqrt #(.IN_W(SQ_W), .STEPS(SQRT_STEPS)) u_sqrt_dd (
    .clk_i  (clk_i),
    .rad_i  (dd2_q),
    .root_o (root_dd)
  );

  lpi_isqrt #(.IN_W(SQ_W), .STEPS(SQRT_STEPS)) u_sqrt_nn (
    .clk_i  (clk_i),
    .rad_i  (SQ_W'(nn2_q)),
    .root_o (root_nn)
  );

  // ---------------------------------------------------------------- stage 3: magnitudes
  logic [MAG_W-1:0] dist_mag;
  logic [MAG_W-1:0] nd_mag;
  side_t            side3_d;

  assign dist_mag = dist2_q[PROD_W-1] ? MAG_W'(-dist2_q) : MAG_W'(dist2_q);
  assign nd_mag   = nd2_q[PROD_W-1] ? MAG_W'(-nd2_q) : MAG_W'(nd2_q);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      side3_d.p[a]   = p2_q[a];
      side3_d.neg[a] = dist2_q[PROD_W-1] ^ d2_q[a][COORD_W-1] ^ nd2_q[PROD_W-1];
    end
    side3_d.degen   = nzero2_q || (dd2_q <= SQ_W'(mm2_q));
    side3_d.nd_zero = (nd2_q == '0);
  end

  logic [LO_W-1:0]  plo3_q [3];
  logic [HI_W-1:0]  phi3_q [3];
  logic [MAG_W-1:0] ndmag3_q;
  side_t            side3_q;

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      plo3_q[a] <= dist_mag[SPLIT_W-1:0] * coord_mag(d2_q[a]);
      phi3_q[a] <= dist_mag[MAG_W-1:SPLIT_W] * coord_mag(d2_q[a]);
    end
    ndmag3_q <= nd_mag;
    side3_q  <= side3_d;
  end

  // ---------------------------------------------------------------- stage 4: numerators
  logic [NUM_W-1:0] num4_q [3];
  logic [MAG_W-1:0] den4_q;

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      num4_q[a] <= (NUM_W'(phi3_q[a]) << SPLIT_W) + NUM_W'(plo3_q[a]);
    end
    den4_q <= ndmag3_q;
  end

  logic [QUOT_W-1:0] quot [3];
  logic              ovf  [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    lpi_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (MAG_W),
      .QUOT_W (QUOT_W),
      .STEPS  (DIV_STEPS)
    ) u_div (
      .clk_i  (clk_i),
      .num_i  (num4_q[a]),
      .den_i  (den4_q),
      .quot_o (quot[a]),
      .ovf_o  (ovf[a])
    );
  end

  // ---------------------------------------------------------------- parallel test
  logic [MAG_W-1:0]    lhs_mag;
  logic [RHS1_W-1:0]   rhs1_q;
  logic [SQ_W/2-1:0]   sd_q;
  logic [RHS_W-1:0]    rhs_q;
  logic                par_q;
  logic                par_late;

  lpi_delay #(.W(MAG_W), .DEPTH(LHS_DEPTH)) u_lhs_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    (ndmag3_q),
    .q_o    (lhs_mag)
  );

  always_ff @(posedge clk_i) begin
    rhs1_q <= par_limit_q * root_nn[NN_W/2-1:0];
    sd_q   <= root_dd;
    rhs_q  <= rhs1_q * sd_q;
    par_q  <= (LHS_W'(lhs_mag) << FIX_SHIFT) < LHS_W'(rhs_q);
  end

  lpi_delay #(.W(1), .DEPTH(PAR_DEPTH)) u_par_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    (par_q),
    .q_o    (par_late)
  );

  side_t side_late;

  lpi_delay #(.W($bits(side_t)), .DEPTH(SIDE_DEPTH)) u_side_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    (side3_q),
    .q_o    (side_late)
  );

  // ---------------------------------------------------------------- output stage
  lpi_result_t res_d;
  lpi_result_t res_q;
  logic [COORD_W-1:0] hit [3];

  always_comb begin
    logic [STEP_W-1:0]     step;
    logic signed [H_W-1:0] hsum;
    for (int a = 0; a < 3; a++) begin
      step = ovf[a] ? STEP_CAP : {1'b0, quot[a]};
      if (side_late.neg[a]) begin
        hsum = H_W'($signed(side_late.p[a])) + H_W'(step);
      end else begin
        hsum = H_W'($signed(side_late.p[a])) - H_W'(step);
      end
      // clamp when the upper bits are not all copies of the sign
      if (hsum[H_W-1:COORD_W-1] != {(H_W-COORD_W+1){hsum[H_W-1]}}) begin
        hit[a] = hsum[H_W-1] ? COORD_MIN : COORD_MAX;
      end else begin
        hit[a] = hsum[COORD_W-1:0];
      end
    end

    res_d = '0;
    if (side_late.degen) begin
      res_d.status = STATUS_DEGEN;
    end else if (side_late.nd_zero || par_late) begin
      res_d.status = STATUS_PARALLEL;
    end else begin
      res_d.status = STATUS_HIT;
      res_d.hit_x  = hit[0];
      res_d.hit_y  = hit[1];
      res_d.hit_z  = hit[2];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  lpi_delay #(.W(1), .DEPTH(LATENCY)) u_valid_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    (start && !busy),
    .q_o    (done_o)
  );

  assign res_o = res_q;

endmodule

// ----- src/lpi_checker.sv -----
// ----------------------------------------------------------------------------
// Line/plane intersection - port checker
// Watches the top-level ports for latency and result consistency.
// ----------------------------------------------------------------------------
`include "line_plane_intersection_top_defines.svh"

module lpi_checker
  import lpi_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input lpi_line_t             line_i,
  input logic                  done_o,
  input lpi_result_t           res_o
);

  logic zero_dir;

  assign zero_dir = (line_i.dir_x == '0) && (line_i.dir_y == '0) && (line_i.dir_z == '0);

  // every strobe answers a word that was accepted earlier
  `LPI_ASSERT_NEVER(a_no_orphan, done_o && !$past(start && !busy, LATENCY), "result without a word")

  // a miss carries a zero point
  `LPI_ASSERT_IMP(a_miss_zero, done_o && (res_o.status != STATUS_HIT), (res_o.hit_x == '0) && (res_o.hit_y == '0) && (res_o.hit_z == '0), "miss with non-zero point")

  // a zero direction is always degenerate
  `LPI_ASSERT_IMP(a_zero_dir, done_o && $past(start && !busy && zero_dir, LATENCY), res_o.status == STATUS_DEGEN, "zero direction not degenerate")

endmodule

bind line_plane_intersection_top lpi_checker u_lpi_checker (.*);
